@@ hw/rtl/fipc_pkg.sv @@
// Package for the Feistel index permuter: types, constants and AES helper functions.
`timescale 1ns / 1ps
`default_nettype none
package fipc_pkg;

  localparam int FEISTEL_ROUNDS = 3;
  localparam int AES_ROUNDS = 10;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_UPPER = 2'd0;
  localparam logic [1:0] CFG_KEY_LOWER = 2'd1;
  localparam logic [1:0] CFG_HALF_WIDTH = 2'd2;

  localparam logic [4:0] HALF_WIDTH_RESET = 5'd8;

  // per-word sideband that rides along the AES pipeline
  typedef struct packed {
    logic [15:0] l;
    logic [15:0] r;
    logic        oor;
  } side_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] v;
    case (rnd)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fipc_aes_cell.sv @@
// One AES round cell: expands its round key from the previous one and applies the round.
`timescale 1ns / 1ps
`default_nettype none
module fipc_aes_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [3:0]     rnd,
  input  wire logic           last,
  input  wire logic           in_valid,
  input  wire logic [127:0]   in_state,
  input  wire logic [127:0]   in_key,
  input  wire fipc_pkg::side_t in_side,
  output logic                out_valid,
  output logic [127:0]        out_state,
  output logic [127:0]        out_key,
  output fipc_pkg::side_t     out_side
);

  logic [7:0]   sb [16];
  logic [7:0]   mc [16];
  logic [127:0] key_nxt;
  logic [127:0] state_nxt;
  logic         valid_r;
  logic [127:0] state_r;
  logic [127:0] key_r;
  fipc_pkg::side_t side_r;

  // key schedule step
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    w0 = in_key[127:96];
    w1 = in_key[95:64];
    w2 = in_key[63:32];
    w3 = in_key[31:0];
    t = {fipc_pkg::sbox(w3[23:16]) ^ fipc_pkg::rcon(rnd), fipc_pkg::sbox(w3[15:8]),
         fipc_pkg::sbox(w3[7:0]), fipc_pkg::sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_nxt = {w0, w1, w2, w3};
  end

  // SubBytes + ShiftRows; byte j is row j%4, column j/4
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      sb[j] = fipc_pkg::sbox(in_state[127 - 8 * ((((j / 4) + (j % 4)) % 4) * 4 + (j % 4)) -: 8]);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0 = sb[c * 4];
      a1 = sb[c * 4 + 1];
      a2 = sb[c * 4 + 2];
      a3 = sb[c * 4 + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        mc[c * 4] = a0;
        mc[c * 4 + 1] = a1;
        mc[c * 4 + 2] = a2;
        mc[c * 4 + 3] = a3;
      end else begin
        mc[c * 4] = a0 ^ all ^ fipc_pkg::xtime(a0 ^ a1);
        mc[c * 4 + 1] = a1 ^ all ^ fipc_pkg::xtime(a1 ^ a2);
        mc[c * 4 + 2] = a2 ^ all ^ fipc_pkg::xtime(a2 ^ a3);
        mc[c * 4 + 3] = a3 ^ all ^ fipc_pkg::xtime(a3 ^ a0);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      state_nxt[127 - 8 * j -: 8] = mc[j] ^ key_nxt[127 - 8 * j -: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r <= key_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_state = state_r;
  assign out_key = key_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

@@ hw/rtl/fipc_feistel_round.sv @@
// One Feistel round: builds the AES block from r, runs ten AES cells, then mixes into l.
`timescale 1ns / 1ps
`default_nettype none
module fipc_feistel_round (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [7:0]      feistel_idx,
  input  wire logic [127:0]    key,
  input  wire logic [4:0]      hw,
  input  wire logic            in_valid,
  input  wire fipc_pkg::side_t in_side,
  output logic                 out_valid,
  output fipc_pkg::side_t      out_side
);

  logic [127:0]    st [fipc_pkg::AES_ROUNDS + 1];
  logic [127:0]    ky [fipc_pkg::AES_ROUNDS + 1];
  logic            vl [fipc_pkg::AES_ROUNDS + 1];
  fipc_pkg::side_t sd [fipc_pkg::AES_ROUNDS + 1];
  logic [4:0]      sh;
  logic [15:0]     top;
  logic [15:0]     f;
  logic [15:0]     mask;

  assign sh = 5'd16 - hw;
  assign mask = 16'((17'd1 << hw) - 17'd1);
  assign top = in_side.r << sh;

  // initial AddRoundKey on the round block
  assign st[0] = {top, 104'd0, feistel_idx} ^ key;
  assign ky[0] = key;
  assign vl[0] = in_valid;
  assign sd[0] = in_side;

  for (genvar k = 0; k < fipc_pkg::AES_ROUNDS; k++) begin : g_cell
    fipc_aes_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .rnd      (4'(k + 1)),
      .last     (k == fipc_pkg::AES_ROUNDS - 1),
      .in_valid (vl[k]),
      .in_state (st[k]),
      .in_key   (ky[k]),
      .in_side  (sd[k]),
      .out_valid(vl[k + 1]),
      .out_state(st[k + 1]),
      .out_key  (ky[k + 1]),
      .out_side (sd[k + 1])
    );
  end

  assign f = (st[fipc_pkg::AES_ROUNDS][127:112] >> sh) & mask;

  always_comb begin
    out_side = sd[fipc_pkg::AES_ROUNDS];
    out_side.l = sd[fipc_pkg::AES_ROUNDS].r;
    out_side.r = (sd[fipc_pkg::AES_ROUNDS].l ^ f) & mask;
  end
  assign out_valid = vl[fipc_pkg::AES_ROUNDS];

endmodule
`default_nettype wire

@@ hw/rtl/feistel_index_permuter_core.sv @@
// Top level of the Feistel index permuter: config registers, input stage, rounds, output.
// Keyed pseudorandom permutation of indices below 2^(2*half_width).
// Input channel: in_valid/in_stall with in_plain_index; one word per cycle while in_stall is low.
// Result channel: out_valid/out_stall with out_permuted_index, out_out_of_range.
// Config: cfg_valid/cfg_ready (always ready), cfg_index 0 key_upper, 1 key_lower,
// 2 half_width; write only while no word is in flight.
// Pipeline: 1 input stage + 10 AES cells per Feistel round (3 rounds) + 1 output
// register = 32 register stages; the input stage loads at the accepting edge.
// Throughput: one word per cycle while the receiver does not stall, set by the fully
// unrolled chain of AES round cells, each one register stage with its own key schedule step.
// Reset clears all valids, keys to zero and half_width to 8.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_stall is raised; otherwise the chain advances every cycle.
`timescale 1ns / 1ps
`default_nettype none
module feistel_index_permuter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_plain_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_permuted_index,
  output logic             out_out_of_range,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]     key_upper_r;
  logic [63:0]     key_lower_r;
  logic [4:0]      half_width_r;
  logic [4:0]      hw;
  logic [15:0]     mask;
  logic            en;
  logic            in_acc;
  logic            s0_valid_r;
  fipc_pkg::side_t s0_side_r;
  fipc_pkg::side_t s0_side_nxt;
  logic            vl [fipc_pkg::FEISTEL_ROUNDS + 1];
  fipc_pkg::side_t sd [fipc_pkg::FEISTEL_ROUNDS + 1];
  logic            out_valid_r;
  logic [31:0]     out_index_r;
  logic            out_oor_r;
  logic [31:0]     result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= 64'd0;
      key_lower_r <= 64'd0;
      half_width_r <= fipc_pkg::HALF_WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fipc_pkg::CFG_KEY_UPPER: key_upper_r <= cfg_data;
        fipc_pkg::CFG_KEY_LOWER: key_lower_r <= cfg_data;
        fipc_pkg::CFG_HALF_WIDTH: half_width_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // saturate to 1..16
  assign hw = (half_width_r == 5'd0) ? 5'd1 : (half_width_r > 5'd16) ? 5'd16 : half_width_r;
  assign mask = 16'((17'd1 << hw) - 17'd1);

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign in_acc = in_valid && en;

  always_comb begin
    s0_side_nxt.oor = (in_plain_index >> {hw, 1'b0}) != 32'd0;
    s0_side_nxt.l = in_plain_index[31:16] & 16'd0 | (16'(in_plain_index >> hw) & mask);
    s0_side_nxt.r = in_plain_index[15:0] & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_side_nxt;
    end
  end

  assign vl[0] = s0_valid_r;
  assign sd[0] = s0_side_r;

  for (genvar i = 0; i < fipc_pkg::FEISTEL_ROUNDS; i++) begin : g_round
    fipc_feistel_round u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .feistel_idx(8'(i + 1)),
      .key        ({key_upper_r, key_lower_r}),
      .hw         (hw),
      .in_valid   (vl[i]),
      .in_side    (sd[i]),
      .out_valid  (vl[i + 1]),
      .out_side   (sd[i + 1])
    );
  end

  assign result = (32'(sd[fipc_pkg::FEISTEL_ROUNDS].l) << hw)
                | 32'(sd[fipc_pkg::FEISTEL_ROUNDS].r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl[fipc_pkg::FEISTEL_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_oor_r <= sd[fipc_pkg::FEISTEL_ROUNDS].oor;
      out_index_r <= sd[fipc_pkg::FEISTEL_ROUNDS].oor ? 32'd0 : result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_permuted_index = out_index_r;
  assign out_out_of_range = out_oor_r;

endmodule
`default_nettype wire

@@ tb/sv/feistel_index_permuter_core_test.sv @@
// Testbench for the Feistel index permuter core: directed and random index streams.
`timescale 1ns / 1ps
module feistel_index_permuter_core_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_plain_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_permuted_index;
  logic        out_out_of_range;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = fipc_pkg::CFG_KEY_UPPER;
  logic [63:0] cfg_data = '0;

  feistel_index_permuter_core DUT (.*);

  always #1 clk = ~clk;

  typedef struct {
    logic [31:0] perm;
    logic        oor;
  } perm_t;

  // local copies of the config registers
  logic [63:0] key_hi = '0;
  logic [63:0] key_lo = '0;
  logic [4:0]  hw_reg = fipc_pkg::HALF_WIDTH_RESET;

  perm_t       expected_q[$];
  int          errors = 0;
  int          stall_left = 0;
  bit          stall_enable = 1'b1;
  int          idle_cycles = 0;
  logic [7:0]  sched[0:175];

  localparam logic [7:0] S[0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] RC[0:9] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // rebuilt whenever a key word changes
  task automatic build_schedule();
    logic [7:0] t[0:3];
    logic [7:0] t0;
    for (int k = 0; k < 8; k++) begin
      sched[k] = key_hi[63 - 8 * k -: 8];
      sched[8 + k] = key_lo[63 - 8 * k -: 8];
    end
    for (int k = 4; k < 44; k++) begin
      for (int j = 0; j < 4; j++) t[j] = sched[(k - 1) * 4 + j];
      if (k % 4 == 0) begin
        t0 = t[0];
        t[0] = S[t[1]] ^ RC[k / 4 - 1];
        t[1] = S[t[2]];
        t[2] = S[t[3]];
        t[3] = S[t0];
      end
      for (int j = 0; j < 4; j++) sched[k * 4 + j] = sched[(k - 4) * 4 + j] ^ t[j];
    end
  endtask

  function automatic logic [15:0] cipher_top(input logic [7:0] s_in[0:15]);
    logic [7:0] s[0:15];
    logic [7:0] t[0:15];
    logic [7:0] a0, a1, a2, a3, al;
    s = s_in;
    for (int j = 0; j < 16; j++) s[j] ^= sched[j];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int j = 0; j < 16; j++) t[j] = S[s[(((j / 4) + (j % 4)) % 4) * 4 + (j % 4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ dbl(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ dbl(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ dbl(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int j = 0; j < 16; j++) s[j] = t[j] ^ sched[rnd * 16 + j];
    end
    return {s[0], s[1]};
  endfunction

  function automatic perm_t permute(input logic [31:0] idx);
    perm_t      res;
    int         hw;
    logic [31:0] mask, l, r, f, tmp;
    logic [15:0] top;
    logic [7:0] blk[0:15];
    hw = hw_reg;
    if (hw < 1) hw = 1;
    if (hw > 16) hw = 16;
    if (64'(idx) >= (64'd1 << (2 * hw))) begin
      res.perm = '0;
      res.oor = 1'b1;
      return res;
    end
    mask = (32'd1 << hw) - 1;
    l = (idx >> hw) & mask;
    r = idx & mask;
    for (int i = 1; i <= fipc_pkg::FEISTEL_ROUNDS; i++) begin
      top = 16'(r << (16 - hw));
      for (int j = 0; j < 16; j++) blk[j] = 8'h00;
      blk[0] = top[15:8];
      blk[1] = top[7:0];
      blk[15] = 8'(i);
      f = (32'(cipher_top(blk)) >> (16 - hw)) & mask;
      tmp = r;
      r = (l ^ f) & mask;
      l = tmp;
    end
    res.perm = (l << hw) + r;
    res.oor = 1'b0;
    return res;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fipc_pkg::CFG_KEY_UPPER: key_hi = val;
      fipc_pkg::CFG_KEY_LOWER: key_lo = val;
      default: hw_reg = val[4:0];
    endcase
    build_schedule();
  endtask

  task automatic send_index(input logic [31:0] idx, input bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 4) : 0;
    if (wait_n != 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_plain_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, permute(idx)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // one result per accepted word
  always @(posedge clk) begin
    perm_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h oor %b", $time, out_permuted_index,
                 out_out_of_range);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_permuted_index !== e.perm) begin
          $display("%0t: permuted_index expected %h actual %h", $time, e.perm,
                   out_permuted_index);
          errors++;
        end
        if (out_out_of_range !== e.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, e.oor,
                   out_out_of_range);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!stall_enable) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) stall_left = $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[feistel_index_permuter_core] ERROR");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    stall_enable = 1'b0;
    send_index(32'h0000_0000, 0);
    send_index(32'h0000_ffff, 0);
    send_index(32'h0001_0000, 0);
    send_index(32'hffff_ffff, 0);
    send_index(32'h0000_1234, 0);
    drain();
    stall_enable = 1'b1;
  endtask

  task automatic test_width_extremes();
    logic [4:0] widths[0:4] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
    cfg_write(fipc_pkg::CFG_KEY_UPPER, 64'hffff_ffff_ffff_ffff);
    cfg_write(fipc_pkg::CFG_KEY_LOWER, 64'h0011_2233_4455_6677);
    foreach (widths[w]) begin
      cfg_write(fipc_pkg::CFG_HALF_WIDTH, 64'(widths[w]));
      send_index(32'h0, 1);
      send_index(32'h3, 1);
      send_index(32'h4, 1);
      send_index(32'hffff_ffff, 1);
      drain();
    end
  endtask

  task automatic test_random_streams();
    logic [31:0] idx;
    int hw;
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(fipc_pkg::CFG_KEY_UPPER, {$urandom, $urandom});
      cfg_write(fipc_pkg::CFG_KEY_LOWER, {$urandom, $urandom});
      cfg_write(fipc_pkg::CFG_HALF_WIDTH, 64'($urandom_range(0, 31)));
      hw = (hw_reg < 1) ? 1 : (hw_reg > 16) ? 16 : hw_reg;
      stall_enable = (ph != 3);
      for (int n = 0; n < 105; n++) begin
        idx = $urandom;
        // mostly in-range words; some land out of range
        if ($urandom_range(0, 9) != 0 && hw < 16) idx = idx & ((32'd1 << (2 * hw)) - 1);
        send_index(idx, ph != 5);
      end
      drain();
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    build_schedule();
    test_reset_defaults();
    test_width_extremes();
    test_random_streams();
    if (errors == 0) $display("[feistel_index_permuter_core] OK");
    else $display("[feistel_index_permuter_core] ERROR");
    $finish;
  end
endmodule
